[rtl/tfc_pkg.sv]
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the telemetry frame checker: request and
// result payloads, the frame event passed from front to back, status codes.
// ----------------------------------------------------------------------------
package tfc_pkg;

  // Frame length default and the depth of the front-to-back event queue
  localparam int FRAME_BYTES_DEFAULT = 5;
  localparam int QUEUE_DEPTH         = 2;

  // Configuration register map
  localparam int             CFG_INDEX_W = 2;
  localparam logic [1:0]     REG_SYNC_VALUE  = 2'd0;
  localparam logic [1:0]     REG_READING_MIN = 2'd1;
  localparam logic [1:0]     REG_READING_MAX = 2'd2;

  // Register reset values
  localparam logic [7:0]         SYNC_RESET        = 8'd170;
  localparam logic signed [15:0] READING_MIN_RESET = -16'sd1000;
  localparam logic signed [15:0] READING_MAX_RESET = 16'sd1000;

  // Saturation limits
  localparam logic [31:0]        COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic signed [47:0] SUM_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN   = 48'sh8000_0000_0000;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SYNC     = 3'd1,
    ST_SUM      = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NO_FRAME = 3'd4
  } status_t;

  // One input request
  typedef struct packed {
    logic [7:0] byte_value;
    logic       stream_end;
  } item_t;

  // One result
  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         node_byte;
    logic signed [15:0] reading;
    logic [31:0]        accepted_count;
    logic [31:0]        rejected_count;
    logic signed [47:0] reading_sum;
    logic               stream_last;
  } result_t;

  // Classified frame event, front to back
  typedef struct packed {
    status_t            status;
    logic [7:0]         node_byte;
    logic signed [15:0] reading;
    logic               last;
  } event_t;

endpackage

[rtl/tfc_front.sv]
// ----------------------------------------------------------------------------
// tfc_front
// Takes stream bytes, tracks the frame position, checksum and held fields,
// classifies each finished frame and emits one event per frame or stream end.
// ----------------------------------------------------------------------------
module tfc_front #(
  parameter int FRAME_BYTES = tfc_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  tfc_pkg::item_t               item,
  input  logic                         cfg_write,
  input  logic [tfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                  cfg_data,
  output logic                         ev_push,
  output tfc_pkg::event_t              ev
);
  import tfc_pkg::*;

  localparam int              POS_W    = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [7:0]         sync_value;
  logic signed [15:0] reading_min;
  logic signed [15:0] reading_max;

  logic [POS_W-1:0]   pos;
  logic [7:0]         csum;
  logic               sync_ok;
  logic [7:0]         held_node;
  logic signed [15:0] held_reading;

  logic               at_last;
  logic               in_range;
  status_t            status;

  // Classify the frame on its checksum byte: sync, checksum, range
  always_comb begin
    at_last  = (pos == LAST_POS);
    in_range = !((held_reading < reading_min) || (held_reading > reading_max));
    if (!sync_ok) begin
      status = ST_SYNC;
    end else if (csum != item.byte_value) begin
      status = ST_SUM;
    end else if (!in_range) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  // Event out: a finished frame, or a stream end inside a frame
  always_comb begin
    ev_push = accept && (at_last || item.stream_end);
    ev.last = item.stream_end;
    if (at_last) begin
      ev.status    = status;
      ev.node_byte = (status == ST_OK) ? held_node : 8'd0;
      ev.reading   = (status == ST_OK) ? held_reading : 16'sd0;
    end else begin
      ev.status    = ST_NO_FRAME;
      ev.node_byte = 8'd0;
      ev.reading   = 16'sd0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value  <= SYNC_RESET;
      reading_min <= READING_MIN_RESET;
      reading_max <= READING_MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SYNC_VALUE:  sync_value  <= cfg_data[7:0];
        REG_READING_MIN: reading_min <= cfg_data;
        REG_READING_MAX: reading_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      csum         <= 8'd0;
      sync_ok      <= 1'b0;
      held_node    <= 8'd0;
      held_reading <= 16'sd0;
    end else if (accept) begin
      if (at_last || item.stream_end) begin
        pos          <= '0;
        csum         <= 8'd0;
        sync_ok      <= 1'b0;
        held_node    <= 8'd0;
        held_reading <= 16'sd0;
      end else begin
        pos  <= pos + 1'b1;
        csum <= csum + item.byte_value;
        case (pos)
          POS_W'(0): sync_ok            <= (item.byte_value == sync_value);
          POS_W'(1): held_node          <= item.byte_value;
          POS_W'(2): held_reading[7:0]  <= item.byte_value;
          POS_W'(3): held_reading[15:8] <= item.byte_value;
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/tfc_queue.sv]
// ----------------------------------------------------------------------------
// tfc_queue
// Short event queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module tfc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  tfc_pkg::event_t wr_data,
  input  logic            rd_en,
  output tfc_pkg::event_t rd_data,
  output logic            q_full,
  output logic            q_valid
);
  import tfc_pkg::*;

  localparam int              PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int              CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  event_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/tfc_back.sv]
// ----------------------------------------------------------------------------
// tfc_back
// Applies frame events to the running totals and holds the result register.
// ----------------------------------------------------------------------------
module tfc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tfc_pkg::event_t  ev,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output tfc_pkg::result_t result
);
  import tfc_pkg::*;

  logic [31:0]        acc_total;
  logic [31:0]        rej_total;
  logic signed [47:0] acc_sum;
  logic               out_valid;

  logic               is_ok;
  logic               is_rej;
  logic [31:0]        acc_total_next;
  logic [31:0]        rej_total_next;
  logic signed [48:0] sum_wide;
  logic signed [47:0] acc_sum_next;

  assign empty = !out_valid;
  assign q_pop = q_valid && (!out_valid || pop);

  // Saturating totals for this event
  always_comb begin
    is_ok  = (ev.status == ST_OK);
    is_rej = (ev.status == ST_SYNC) || (ev.status == ST_SUM) || (ev.status == ST_RANGE);
    acc_total_next = (is_ok && acc_total != COUNT_MAX) ? acc_total + 32'd1 : acc_total;
    rej_total_next = (is_rej && rej_total != COUNT_MAX) ? rej_total + 32'd1 : rej_total;
    sum_wide = {acc_sum[47], acc_sum} + 49'(ev.reading);
    if (!is_ok) begin
      acc_sum_next = acc_sum;
    end else if (sum_wide[48] != sum_wide[47]) begin
      acc_sum_next = sum_wide[48] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sum_next = sum_wide[47:0];
    end
  end

  // Totals; cleared after a stream end
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_total <= 32'd0;
      rej_total <= 32'd0;
      acc_sum   <= 48'sd0;
    end else if (q_pop) begin
      if (ev.last) begin
        acc_total <= 32'd0;
        rej_total <= 32'd0;
        acc_sum   <= 48'sd0;
      end else begin
        acc_total <= acc_total_next;
        rej_total <= rej_total_next;
        acc_sum   <= acc_sum_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.status         <= ev.status;
      result.node_byte      <= ev.node_byte;
      result.reading        <= ev.reading;
      result.accepted_count <= acc_total_next;
      result.rejected_count <= rej_total_next;
      result.reading_sum    <= acc_sum_next;
      result.stream_last    <= ev.last;
    end
  end

endmodule

[rtl/telemetry_frame_checker_unit.sv]
// ----------------------------------------------------------------------------
// telemetry_frame_checker_unit
// Checks a framed telemetry byte stream: sync byte, additive checksum and
// reading range, with saturating running totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive item and raise push; a byte is taken when push is high
//   and full is low. One byte per cycle is sustained while full stays low.
//   Result queue: while empty is low, result holds the oldest result; pop
//   takes it. A result appears on the last byte of each frame, and on a
//   stream-end byte inside a frame (status no_frame).
//   Path: a result passes through the event queue (front classifies into it)
//   and then the result register (back updates the totals into it).
//   Throughput is one byte and one result per cycle while pop keeps up; the
//   back stage updates the totals once per cycle while it takes an event.
//   Stall: when pop stays low, the result register holds and the two-entry
//   event queue fills; full rises only once it is full, so bytes inside a
//   frame keep flowing until the queue is reached.
//   Configuration: cfg_ready is always high; write only while idle.
//   Reset: frame state, totals and queues clear; registers take their
//   defaults (sync 170, range -1000..1000). No clearing pass.
// ----------------------------------------------------------------------------
module telemetry_frame_checker_unit #(
  parameter int FRAME_BYTES = tfc_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  tfc_pkg::item_t                  item,
  output logic                            empty,
  input  logic                            pop,
  output tfc_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import tfc_pkg::*;

  logic   accept;
  logic   ev_push;
  event_t ev_in;
  event_t ev_out;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  tfc_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ev_push  (ev_push),
    .ev       (ev_in)
  );

  tfc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (ev_push),
    .wr_data(ev_in),
    .rd_en  (q_pop),
    .rd_data(ev_out),
    .q_full (q_full),
    .q_valid(q_valid)
  );

  tfc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .ev     (ev_out),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  // A no_frame result always closes the stream
  a_noframe_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_NO_FRAME) |-> result.stream_last)
    else $error("no_frame result without stream_last");

  // Rejected frames carry no node or reading
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_OK) |-> (result.node_byte == 8'd0 && result.reading == 16'sd0))
    else $error("rejected result with payload");

  // A stream-end byte produces a visible result after the event queue and the result register
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (accept && item.stream_end) |=> ##1 !empty)
    else $error("stream end gave no result");

  // Results never carry an unknown status code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status == ST_OK || result.status == ST_SYNC ||
                result.status == ST_SUM || result.status == ST_RANGE ||
                result.status == ST_NO_FRAME))
    else $error("bad status code");

endmodule
